FILE: design/assert_macros.svh
// Concurrent assertion helpers; clk and rst_n come from the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define CKFL_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define CKFL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define CKFL_ASSERT(lbl, cond)
`define CKFL_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

FILE: design/ckfl_pkg.sv
`timescale 1ns / 1ps

package ckfl_pkg;

    localparam int MAX_K           = 31;
    localparam int KEY_W           = 62;
    localparam int FREQ_W          = 32;
    localparam int KSZ_W           = 5;
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam logic [KSZ_W-1:0] KSZ_RESET = 5'd31;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_READ,
        ST_CMP
    } ckfl_state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic idx_inc;
        logic commit_hit;
        logic commit_miss;
    } ckfl_cmd_t;

    typedef struct packed {
        logic accept_probe;
        logic is_insert;
        logic idx_at_end;
        logic match;
        logic out_busy;
    } ckfl_status_t;

    // Reverse complement over all MAX_K base slots.
    function automatic logic [KEY_W-1:0] revcomp_full(input logic [KEY_W-1:0] x);
        logic [KEY_W-1:0] r;
        r = '0;
        for (int i = 0; i < MAX_K; i++)
        begin
            r[2*i +: 2] = ~x[2*(MAX_K-1-i) +: 2];
        end
        return r;
    endfunction

endpackage

FILE: design/ckfl_ram.sv
`timescale 1ns / 1ps

module ckfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/ckfl_ctrl.sv
`timescale 1ns / 1ps

module ckfl_ctrl
    import ckfl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  ckfl_status_t status,
    output ckfl_cmd_t    cmd
);

    ckfl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.accept_probe)
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                if (status.idx_at_end)
                begin
                    if (status.is_insert || !status.out_busy)
                    begin
                        cmd.commit_miss = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (status.match)
                begin
                    if (status.is_insert || !status.out_busy)
                    begin
                        cmd.commit_hit = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/ckfl_dp.sv
`timescale 1ns / 1ps

module ckfl_dp
    import ckfl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [KSZ_W-1:0]  cfg_wdata,
    input  logic              action,
    input  logic [KEY_W-1:0]  entry_key,
    input  logic [FREQ_W-1:0] entry_freq,
    input  logic [1:0]        base,
    input  logic              first_of_read,
    input  logic              last_of_read,
    input  ckfl_cmd_t         cmd,
    output ckfl_status_t      status,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [FREQ_W-1:0] freq,
    output logic              last_result,
    output logic              table_overflow
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = $clog2(TABLE_DEPTH + 1);

    logic [KSZ_W-1:0]  ksz_reg, ksz_next;
    logic [KEY_W-1:0]  fwd_reg, fwd_next;
    logic [KSZ_W-1:0]  seen_reg, seen_next;
    logic [IW-1:0]     used_reg, used_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic              ovf_reg, ovf_next;
    logic              ovalid_reg, ovalid_next;
    logic [FREQ_W-1:0] ofreq_reg;
    logic              olast_reg;
    logic              oovf_reg;
    logic              ins_reg;
    logic              last_reg;
    logic [KEY_W-1:0]  probe_reg;
    logic [KEY_W-1:0]  ckey_reg;
    logic [FREQ_W-1:0] efreq_reg;

    logic [KSZ_W-1:0]  k_eff;
    logic [KEY_W-1:0]  mask;
    logic [KEY_W-1:0]  fwd_base;
    logic [KEY_W-1:0]  fwd_shift;
    logic [KSZ_W-1:0]  seen_base;
    logic [KSZ_W-1:0]  seen_inc;
    logic [KEY_W-1:0]  rc;
    logic [KEY_W-1:0]  key_q;
    logic [FREQ_W-1:0] cnt_q;
    logic              has_room;
    logic              key_we;
    logic              cnt_we;
    logic [AW-1:0]     waddr;
    logic              out_load;
    logic [FREQ_W-1:0] out_val;

    always_comb
    begin
        k_eff = (ksz_reg == '0) ? KSZ_W'(1) : ksz_reg;
        if (k_eff > KSZ_W'(MAX_K))
        begin
            k_eff = KSZ_W'(MAX_K);
        end
        mask = (KEY_W'(1) << {k_eff, 1'b0}) - KEY_W'(1);
    end

    assign fwd_base  = first_of_read ? '0 : fwd_reg;
    assign seen_base = first_of_read ? '0 : seen_reg;
    assign fwd_shift = {fwd_base[KEY_W-3:0], base};
    assign seen_inc  = (seen_base < KSZ_W'(MAX_K)) ? seen_base + KSZ_W'(1) : seen_base;
    assign rc        = revcomp_full(probe_reg) >> {KSZ_W'(MAX_K) - k_eff, 1'b0};
    assign has_room  = used_reg < IW'(TABLE_DEPTH);

    assign status.accept_probe = !action || (seen_inc >= k_eff);
    assign status.is_insert    = ins_reg;
    assign status.idx_at_end   = idx_reg == used_reg;
    assign status.match        = key_q == ckey_reg;
    assign status.out_busy     = ovalid_reg && !out_ready;

    assign key_we = cmd.commit_miss && ins_reg && has_room;
    assign cnt_we = (cmd.commit_hit && ins_reg) || key_we;
    assign waddr  = cmd.commit_hit ? idx_reg[AW-1:0] : used_reg[AW-1:0];

    assign out_load = (cmd.commit_hit || cmd.commit_miss) && !ins_reg;
    assign out_val  = cmd.commit_hit ? cnt_q : FREQ_W'(1);

    ckfl_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_keys (
        .clk   (clk),
        .we    (key_we),
        .waddr (waddr),
        .wdata (ckey_reg),
        .raddr (idx_reg[AW-1:0]),
        .rdata (key_q)
    );

    ckfl_ram #(.WIDTH(FREQ_W), .DEPTH(TABLE_DEPTH)) u_counts (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (waddr),
        .wdata (efreq_reg),
        .raddr (idx_reg[AW-1:0]),
        .rdata (cnt_q)
    );

    always_comb
    begin
        ksz_next    = cfg_we ? cfg_wdata : ksz_reg;
        fwd_next    = fwd_reg;
        seen_next   = seen_reg;
        if (cmd.load && action)
        begin
            fwd_next  = last_of_read ? '0 : fwd_shift;
            seen_next = last_of_read ? '0 : seen_inc;
        end
        idx_next = idx_reg;
        if (cmd.prep)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IW'(1);
        end
        used_next   = key_we ? used_reg + IW'(1) : used_reg;
        ovf_next    = ovf_reg || (cmd.commit_miss && ins_reg && !has_room);
        ovalid_next = out_load || (ovalid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ksz_reg    <= KSZ_RESET;
            fwd_reg    <= '0;
            seen_reg   <= '0;
            used_reg   <= '0;
            idx_reg    <= '0;
            ovf_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ksz_reg    <= ksz_next;
            fwd_reg    <= fwd_next;
            seen_reg   <= seen_next;
            used_reg   <= used_next;
            idx_reg    <= idx_next;
            ovf_reg    <= ovf_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ins_reg   <= !action;
            last_reg  <= last_of_read;
            efreq_reg <= entry_freq;
            probe_reg <= (action ? fwd_shift : entry_key) & mask;
        end
        if (cmd.prep)
        begin
            ckey_reg <= (probe_reg < rc) ? probe_reg : rc;
        end
        if (out_load)
        begin
            ofreq_reg <= out_val;
            olast_reg <= last_reg;
            oovf_reg  <= ovf_reg;
        end
    end

    assign out_valid      = ovalid_reg;
    assign freq           = ofreq_reg;
    assign last_result    = olast_reg;
    assign table_overflow = oovf_reg;

endmodule

FILE: design/canonical_kmer_frequency_lookup.sv
`timescale 1ns / 1ps
// Canonical k-mer frequency lookup.
// Input stream (s_axis): tuser = action (0 insert, 1 read base), tlast = last
// base of a read, tdata = entry_key, entry_freq, base, first_of_read.
// Output stream (m_axis): tdata = freq, tlast = last base of the read,
// tuser = sticky table overflow flag. kmer_size is written through cfg_we.
// Inserts and lookups scan the filled table entries linearly, one RAM read
// and one compare per entry. A hit commits on the matching entry and a miss
// after the last filled entry; the result is valid from the cycle after the
// commit. A read base that yields no k-mer yet starts no scan. One item is
// in work at a time; the next is accepted as soon as the scan ends, even
// while a result waits. A stalled receiver holds the result; a later lookup
// waits at its last scan step until the result register frees up. Inserts
// never wait on it. Reset clears the window, the fill count and the overflow
// flag and sets kmer_size to 31; the table contents need no clearing pass.

`include "assert_macros.svh"

module canonical_kmer_frequency_lookup
    import ckfl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [KSZ_W-1:0]   cfg_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // entry_key[61:0], entry_freq[93:62], base[95:94], first_of_read[96], zero
    input  logic [103:0]       s_axis_tdata,
    // action
    input  logic               s_axis_tuser,
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // freq[31:0]
    output logic [FREQ_W-1:0]  m_axis_tdata,
    // table_overflow
    output logic               m_axis_tuser,
    output logic               m_axis_tlast
);

    ckfl_cmd_t    cmd;
    ckfl_status_t status;

    ckfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ckfl_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .action         (s_axis_tuser),
        .entry_key      (s_axis_tdata[61:0]),
        .entry_freq     (s_axis_tdata[93:62]),
        .base           (s_axis_tdata[95:94]),
        .first_of_read  (s_axis_tdata[96]),
        .last_of_read   (s_axis_tlast),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .freq           (m_axis_tdata),
        .last_result    (m_axis_tlast),
        .table_overflow (m_axis_tuser)
    );

    `CKFL_ASSERT_IMP(a_load_on_handshake, cmd.load, s_axis_tvalid && s_axis_tready)
    `CKFL_ASSERT(a_single_commit, !(cmd.commit_hit && cmd.commit_miss))
    `CKFL_ASSERT_IMP(a_no_result_overrun, (cmd.commit_hit || cmd.commit_miss)
        && !status.is_insert, !status.out_busy)
    `CKFL_ASSERT_IMP(a_busy_no_accept, cmd.prep, !s_axis_tready)

endmodule

FILE: dv/tb_canonical_kmer_frequency_lookup.sv
`timescale 1ns / 1ps

module tb_canonical_kmer_frequency_lookup;
    import ckfl_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam longint CYCLE_LIMIT = 20000000;
    localparam int SCAN_DRAIN = 2 * DEPTH + 64;
    localparam bit ACT_INSERT = 1'b0;
    localparam bit ACT_BASE = 1'b1;

    typedef struct {
        logic [FREQ_W-1:0] freq;
        logic              last;
        logic              ovf;
    } lookup_result_t;

    class kmer_freq_model;
        int unsigned       ksz;
        logic [KEY_W-1:0]  fwd_win;
        int unsigned       seen;
        logic [KEY_W-1:0]  keys [DEPTH];
        logic [FREQ_W-1:0] counts [DEPTH];
        int unsigned       used;
        bit                ovf;
        lookup_result_t    freq_q[$];
        int unsigned       errors;

        function new();
            ksz = KSZ_RESET;
            fwd_win = '0;
            seen = 0;
            used = 0;
            ovf = 0;
            errors = 0;
        endfunction

        function int unsigned eff_k();
            return (ksz == 0) ? 1 : ((ksz > MAX_K) ? MAX_K : ksz);
        endfunction

        function logic [KEY_W-1:0] kmask(int unsigned k);
            logic [63:0] m;
            m = (64'd1 << (2 * k)) - 64'd1;
            return m[KEY_W-1:0];
        endfunction

        function logic [KEY_W-1:0] rc(logic [KEY_W-1:0] x, int unsigned k);
            logic [KEY_W-1:0] r;
            r = '0;
            for (int i = 0; i < k; i++)
            begin
                r = (r << 2) | KEY_W'(2'd3 - x[1:0]);
                x = x >> 2;
            end
            return r;
        endfunction

        function logic [KEY_W-1:0] canonical(logic [KEY_W-1:0] x, int unsigned k);
            logic [KEY_W-1:0] r;
            r = rc(x, k);
            return (x < r) ? x : r;
        endfunction

        function int lookup(logic [KEY_W-1:0] key);
            for (int i = 0; i < used; i++)
            begin
                if (keys[i] == key)
                    return i;
            end
            return -1;
        endfunction

        function void note_input(bit act, logic [KEY_W-1:0] key, logic [FREQ_W-1:0] fr,
                                 logic [1:0] b, bit first, bit last);
            int unsigned k;
            logic [KEY_W-1:0] ck;
            int pos;
            lookup_result_t res;
            k = eff_k();
            if (act == ACT_INSERT)
            begin
                ck = canonical(key & kmask(k), k);
                pos = lookup(ck);
                if (pos >= 0)
                    counts[pos] = fr;
                else if (used < DEPTH)
                begin
                    keys[used] = ck;
                    counts[used] = fr;
                    used++;
                end
                else
                    ovf = 1;
                return;
            end
            if (first)
            begin
                fwd_win = '0;
                seen = 0;
            end
            fwd_win = (fwd_win << 2) | KEY_W'(b);
            if (seen < MAX_K)
                seen++;
            if (seen >= k)
            begin
                pos = lookup(canonical(fwd_win & kmask(k), k));
                res.freq = (pos >= 0) ? counts[pos] : 32'd1;
                res.last = last;
                res.ovf = ovf;
                freq_q.push_back(res);
            end
            if (last)
            begin
                fwd_win = '0;
                seen = 0;
            end
        endfunction

        function void check_result(logic [FREQ_W-1:0] fr, logic last, logic ov);
            lookup_result_t e;
            if (freq_q.size() == 0)
            begin
                $display("%0t: unexpected result freq=%0h last=%0b ovf=%0b", $time, fr, last, ov);
                errors++;
                return;
            end
            e = freq_q.pop_front();
            if (fr !== e.freq)
            begin
                $display("%0t: freq expected %0h actual %0h", $time, e.freq, fr);
                errors++;
            end
            if (last !== e.last)
            begin
                $display("%0t: last expected %0b actual %0b", $time, e.last, last);
                errors++;
            end
            if (ov !== e.ovf)
            begin
                $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, ov);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 0;
    logic               rst_n = 0;
    logic               cfg_we = 0;
    logic [KSZ_W-1:0]   cfg_wdata = '0;
    logic               s_axis_tvalid = 0;
    logic               s_axis_tready;
    logic [103:0]       s_axis_tdata = '0;
    logic               s_axis_tuser = 0;
    logic               s_axis_tlast = 0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 0;
    logic [FREQ_W-1:0]  m_axis_tdata;
    logic               m_axis_tuser;
    logic               m_axis_tlast;

    kmer_freq_model model = new();
    bit no_idle = 0;
    bit long_hold_req = 0;
    longint cycles = 0;
    logic [KEY_W-1:0] stored_keys[$];

    canonical_kmer_frequency_lookup u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver back-pressure
    initial
    begin
        int hold;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 0;
                hold = 3000;
            end
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 0;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 18) - 1;
                m_axis_tready <= 0;
            end
            else
                m_axis_tready <= 1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            model.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    task automatic send(bit act, logic [KEY_W-1:0] key, logic [FREQ_W-1:0] fr,
                        logic [1:0] b, bit first, bit last);
        bit acc;
        if (!no_idle && $urandom_range(0, 9) == 0)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= act;
        s_axis_tlast <= last;
        s_axis_tdata <= {7'd0, first, b, fr, key};
        do
        begin
            @(negedge clk);
            acc = s_axis_tready;
            @(posedge clk);
        end
        while (!acc);
        model.note_input(act, key, fr, b, first, last);
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[KEY_W-1:0];
    endfunction

    task automatic insert_entry(logic [KEY_W-1:0] key, logic [FREQ_W-1:0] fr);
        send(ACT_INSERT, key, fr, 2'($urandom()), 1'($urandom()), 1'($urandom()));
    endtask

    task automatic feed_base(logic [1:0] b, bit first, bit last);
        send(ACT_BASE, rand_key(), $urandom(), b, first, last);
    endtask

    // feeds a read: the k bases of key (first base from the top), then extra random bases
    task automatic feed_read(logic [KEY_W-1:0] key, int unsigned k, int extra, bit set_first);
        int n;
        n = k + extra;
        for (int i = 0; i < n; i++)
        begin
            logic [1:0] b;
            b = (i < k) ? key[2*(k-1-i) +: 2] : 2'($urandom());
            feed_base(b, set_first && i == 0, i == n - 1);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge clk);
        wait (model.freq_q.size() == 0);
        repeat (SCAN_DRAIN) @(posedge clk);
    endtask

    task automatic write_ksize(logic [KSZ_W-1:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
        model.ksz = v;
        stored_keys.delete();
        @(posedge clk);
    endtask

    task automatic random_phase(int n_items, bit hold, bit pause);
        int done;
        int unsigned k;
        logic [KEY_W-1:0] key;
        done = 0;
        k = model.eff_k();
        if (hold)
            long_hold_req = 1;
        while (done < n_items)
        begin
            if (pause && done > n_items / 2)
            begin
                pause = 0;
                s_axis_tvalid <= 0;
                @(posedge clk);
                wait (model.freq_q.size() == 0);
                @(posedge clk);
            end
            if ($urandom_range(0, 99) < 12)
            begin
                key = rand_key();
                insert_entry(key, $urandom());
                stored_keys.push_back(key & model.kmask(k));
                done++;
            end
            else
            begin
                int extra;
                extra = $urandom_range(0, 4);
                if (stored_keys.size() > 0 && $urandom_range(0, 1) == 1)
                begin
                    key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                    if ($urandom_range(0, 1) == 1)
                        key = model.rc(key, k);
                end
                else
                begin
                    key = rand_key();
                    if ($urandom_range(0, 3) == 0)
                        k = $urandom_range(1, model.eff_k());
                end
                feed_read(key, k, extra, $urandom_range(0, 9) != 0);
                done += k + extra;
                k = model.eff_k();
            end
        end
    endtask

    initial
    begin
        logic [KEY_W-1:0] key;
        logic [KSZ_W-1:0] ksizes[$];
        ksizes = '{5'd1, 5'd2, 5'd3, 5'd0, 5'd4, 5'd5, 5'd7, 5'd12, 5'd20, 5'd31};
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed, k = 31 after reset
        insert_entry('0, 32'd0);
        insert_entry({KEY_W{1'b1}}, 32'hFFFF_FFFF);
        key = rand_key();
        insert_entry(key, 32'd77);
        feed_read('0, 31, 0, 1);
        feed_read(key, 31, 0, 1);
        feed_read(model.rc(key, 31), 31, 1, 0);
        feed_read(rand_key(), 5, 0, 1);
        feed_read(rand_key(), 31, 2, 0);
        write_ksize(5'd3);
        insert_entry({KEY_W{1'b1}} ^ 62'h3F, 32'h1234_5678);
        feed_read(62'h0, 3, 0, 1);
        feed_base(2'd3, 1, 0);
        feed_base(2'd3, 1, 0);
        feed_base(2'd0, 0, 1);

        foreach (ksizes[i])
        begin
            write_ksize(ksizes[i]);
            random_phase(20, i == 2, i == 5);
        end

        // fill the table to overflow, k = 31
        drain();
        no_idle = 1;
        while (model.used < DEPTH)
        begin
            key = rand_key();
            insert_entry(key, $urandom());
            if (stored_keys.size() < 8)
                stored_keys.push_back(key);
        end
        feed_read(stored_keys[0], 31, 0, 1);
        for (int i = 0; i < 3; i++)
            insert_entry(rand_key(), $urandom());
        insert_entry(stored_keys[1], 32'hDEAD_BEEF);
        for (int i = 0; i < 3; i++)
            feed_read(stored_keys[i], 31, $urandom_range(0, 1), 1);
        feed_read(rand_key(), 31, 1, 1);

        drain();
        if (model.errors == 0 && model.freq_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/ckfl_pkg.sv
design/ckfl_ram.sv
design/ckfl_ctrl.sv
design/ckfl_dp.sv
design/canonical_kmer_frequency_lookup.sv
dv/tb_canonical_kmer_frequency_lookup.sv
